// ----- hw/rtl/scanned_channel_ema_smoother_macros.svh -----
// assertion macros for the scanned channel smoother
`ifndef SCANNED_CHANNEL_EMA_SMOOTHER_MACROS_SVH
`define SCANNED_CHANNEL_EMA_SMOOTHER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SCES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SCES_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SCES_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/sces_pkg.sv -----
// shared types and constants for the scanned channel smoother
package sces_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int SMOOTH_SHIFT = 9;
    localparam int SAMPLE_BITS  = 12;
    localparam int ACC_BITS     = SAMPLE_BITS + SMOOTH_SHIFT;

    // fixed field widths of the stream items
    localparam int POS_W        = 3;
    localparam int SMOOTH_W     = 12;
    localparam int SEL_W        = 5;
    localparam int NUM_SCAN     = 8;
    localparam int CFG_IDX_W    = 3;

    localparam int IN_TDATA_W   = 16;
    localparam int OUT_ITEM_W   = POS_W + SMOOTH_W + SEL_W;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [SEL_W-1:0] SCAN_RESET [NUM_SCAN] = '{
        5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd29, 5'd30
    };

    typedef logic [POS_W-1:0] t_pos;

    // result of one accumulator update
    typedef struct packed {
        t_pos                pos;
        t_pos                next_pos;
        logic [SMOOTH_W-1:0] smoothed;
    } t_acc_res;

    // output item, first field in the high bits
    typedef struct packed {
        logic [SEL_W-1:0]    next_input_select;
        logic [SMOOTH_W-1:0] smoothed_value;
        t_pos                channel_index;
    } t_out_item;

endpackage

// ----- hw/rtl/sces_chan_acc.sv -----
// per-channel accumulators, scan position and the smoothing update
module sces_chan_acc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_upd,
    input  logic [sces_pkg::SAMPLE_BITS-1:0]  i_sample,
    output sces_pkg::t_acc_res                o_res
);

    logic [sces_pkg::ACC_BITS-1:0] r_acc [sces_pkg::NUM_CHANNELS];
    sces_pkg::t_pos                r_pos;

    logic [sces_pkg::ACC_BITS-1:0] cur_acc;
    logic [sces_pkg::ACC_BITS:0]   sum_acc;
    logic [sces_pkg::ACC_BITS-1:0] n_acc;
    sces_pkg::t_pos                n_pos;

    always_comb begin
        cur_acc = r_acc[r_pos];
        // acc + sample - (acc >> shift), one extra bit for the carry
        sum_acc = {1'b0, cur_acc}
                + {{(sces_pkg::ACC_BITS + 1 - sces_pkg::SAMPLE_BITS){1'b0}}, i_sample}
                - {{(sces_pkg::SMOOTH_SHIFT + 1){1'b0}},
                   cur_acc[sces_pkg::ACC_BITS-1:sces_pkg::SMOOTH_SHIFT]};
        n_acc   = sum_acc[sces_pkg::ACC_BITS-1:0];
        if (r_pos >= sces_pkg::t_pos'(sces_pkg::NUM_CHANNELS - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + 1'b1;
        end
        o_res.pos      = r_pos;
        o_res.next_pos = n_pos;
        o_res.smoothed = sces_pkg::SMOOTH_W'(n_acc >> sces_pkg::SMOOTH_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int i = 0; i < sces_pkg::NUM_CHANNELS; i++) begin
                r_acc[i] <= '0;
            end
        end else if (i_upd) begin
            r_pos        <= n_pos;
            r_acc[r_pos] <= n_acc;
        end
    end

endmodule

// ----- hw/rtl/scanned_channel_ema_smoother.sv -----
// top level of the scanned channel exponential smoother
//
// one raw converter sample enters per transaction on the s_axis side and
// belongs to the channel at the current scan position (0..7, wrapping).
// that channel's accumulator becomes acc + sample - (acc >> 9) and one
// result leaves on the m_axis side: scan position, acc >> 9 and the
// converter input to select for the next conversion, read from the scan
// table written over the cfg port (index 0..7, one 5-bit entry each).
// the result is registered into the output stage; a new sample can be
// taken every cycle while s_axis_tready is high, with a read-modify-write
// of the accumulator bank for each accepted sample.
// the output side has a main register and a skid register, so s_axis_tready
// is registered and stays high while one result waits; it drops once two
// results are held and rises again when the receiver takes one.
// reset clears the accumulators, the scan position and the output stage,
// and loads the scan table with its default inputs (16..21, 29, 30).
// the scan table is meant to be written only while the block is idle.
`include "scanned_channel_ema_smoother_macros.svh"

module scanned_channel_ema_smoother (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // cfg write port
    input  logic                                i_cfg_we,
    input  logic [sces_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sces_pkg::SEL_W-1:0]          i_cfg_wdata,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sces_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [11:0] sample
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] channel_index, [14:3] smoothed_value, [19:15] next_input_select
    output logic [sces_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic [sces_pkg::SEL_W-1:0] r_scan [sces_pkg::NUM_SCAN];

    sces_pkg::t_acc_res  acc_res;
    sces_pkg::t_out_item n_item;
    sces_pkg::t_out_item r_out;
    sces_pkg::t_out_item r_skid;
    logic                r_out_valid;
    logic                r_skid_valid;
    logic                in_xfer;
    logic                out_xfer;

    assign s_axis_tready = !r_skid_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = r_out_valid && m_axis_tready;

    sces_chan_acc u_chan_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (in_xfer),
        .i_sample (s_axis_tdata[sces_pkg::SAMPLE_BITS-1:0]),
        .o_res    (acc_res)
    );

    always_comb begin
        n_item.channel_index     = acc_res.pos;
        n_item.smoothed_value    = acc_res.smoothed;
        n_item.next_input_select = r_scan[acc_res.next_pos];
    end

    // scan table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sces_pkg::NUM_SCAN; i++) begin
                r_scan[i] <= sces_pkg::SCAN_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_scan[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    // output register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (in_xfer) begin
                r_out       <= n_item;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (in_xfer) begin
            if (!r_out_valid) begin
                r_out       <= n_item;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_item;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(sces_pkg::OUT_TDATA_W - sces_pkg::OUT_ITEM_W){1'b0}}, r_out};

    `SCES_ASSERT_IMPL(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `SCES_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, in_xfer && r_out_valid && !m_axis_tready, r_skid_valid && r_out_valid)
    `SCES_ASSERT_NEXT(a_cfg_write_lands, i_clk, i_rst_n, i_cfg_we, r_scan[$past(i_cfg_idx)] == $past(i_cfg_wdata))
    `SCES_ASSERT_NEXT(a_idle_holds_out, i_clk, i_rst_n, r_out_valid && !m_axis_tready, r_out_valid && $stable(r_out))

endmodule
